FILE: design/sdd_pkg.sv
// Shared constants, types and helpers for the directional difference block.
package sdd_pkg;

  localparam int ROWS   = 8;
  localparam int COLS   = 8;
  localparam int PIX    = ROWS * COLS;
  localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int CNT_W  = $clog2(PIX + 1);
  localparam int PIX_W  = 16;
  localparam int DIFF_W = 17;
  localparam int POS_W  = 3;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } sdd_state_e;

  // read beat in flight: what the RAM outputs currently hold
  typedef struct packed {
    logic             dv;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } sdd_rd_meta_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
    logic [POS_W+CNT_W-1:0] a;
    a = (POS_W+CNT_W)'(r) * (POS_W+CNT_W)'(COLS) + (POS_W+CNT_W)'(c);
    return a[ADDR_W-1:0];
  endfunction

endpackage

FILE: design/sdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sdd_ctrl.sv
// Load counter, emit address sequencer and RAM read control.
module sdd_ctrl import sdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_n_o,
  output logic [ADDR_W-1:0] raddr_c_o,
  output logic [ADDR_W-1:0] raddr_s_o,
  output logic [ADDR_W-1:0] raddr_w_o,
  output sdd_rd_meta_t      meta_o,
  input  logic              take_i
);

  sdd_state_e       state_q, state_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [POS_W-1:0] rd_row_q, rd_row_d;
  logic [POS_W-1:0] rd_col_q, rd_col_d;
  logic             more_q, more_d;
  logic             dv_q, dv_d;
  logic [POS_W-1:0] mrow_q, mcol_q;
  logic             mlast_q;
  logic             accept;
  logic [POS_W-1:0] rn, rs, cw;

  assign accept = in_valid_i && !in_stall_o;
  assign we_o    = accept;
  assign waddr_o = load_cnt_q[ADDR_W-1:0];

  assign rn = (rd_row_q == '0) ? '0 : rd_row_q - POS_W'(1);
  assign rs = (rd_row_q == POS_W'(ROWS - 1)) ? rd_row_q : rd_row_q + POS_W'(1);
  assign cw = (rd_col_q == '0) ? '0 : rd_col_q - POS_W'(1);

  assign raddr_n_o = pix_addr(rn, rd_col_q);
  assign raddr_c_o = pix_addr(rd_row_q, rd_col_q);
  assign raddr_s_o = pix_addr(rs, rd_col_q);
  assign raddr_w_o = pix_addr(rd_row_q, cw);

  assign meta_o = '{dv: dv_q, row: mrow_q, col: mcol_q, last: mlast_q};

  // outputs
  always_comb begin
    in_stall_o = 1'b1;
    re_o       = 1'b0;
    unique case (state_q)
      ST_LOAD: in_stall_o = 1'b0;
      ST_EMIT: re_o = more_q && (!dv_q || take_i);
      default: in_stall_o = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    rd_row_d   = rd_row_q;
    rd_col_d   = rd_col_q;
    more_d     = more_q;
    dv_d       = dv_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (load_cnt_q == CNT_W'(PIX - 1)) begin
            load_cnt_d = '0;
            state_d    = ST_EMIT;
            rd_row_d   = POS_W'(ROWS - 1);
            rd_col_d   = POS_W'(COLS - 1);
            more_d     = 1'b1;
          end else begin
            load_cnt_d = load_cnt_q + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (re_o) begin
          dv_d = 1'b1;
          if (rd_col_q == '0) begin
            if (rd_row_q == '0) begin
              more_d = 1'b0;
            end else begin
              rd_row_d = rd_row_q - POS_W'(1);
              rd_col_d = POS_W'(COLS - 1);
            end
          end else begin
            rd_col_d = rd_col_q - POS_W'(1);
          end
        end else if (take_i) begin
          dv_d = 1'b0;
          if (!more_q) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
      more_q     <= 1'b0;
      dv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      rd_row_q   <= rd_row_d;
      rd_col_q   <= rd_col_d;
      more_q     <= more_d;
      dv_q       <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_o) begin
      mrow_q  <= rd_row_q;
      mcol_q  <= rd_col_q;
      mlast_q <= (rd_row_q == '0) && (rd_col_q == '0);
    end
  end

  // held read data must not be overwritten before it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q && !take_i |-> !re_o)
    else $error("read issued over untaken data");

  a_no_rd_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |-> state_q == ST_EMIT && !we_o)
    else $error("read during load");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && mlast_q |=> state_q == ST_LOAD && load_cnt_q == '0)
    else $error("block did not return to load");

  a_take_dv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> dv_q)
    else $error("take without data");

endmodule

FILE: design/sdd_out.sv
// Difference datapath and output register.
module sdd_out import sdd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdd_rd_meta_t             meta_i,
  input  logic [PIX_W-1:0]         q_n_i,
  input  logic [PIX_W-1:0]         q_c_i,
  input  logic [PIX_W-1:0]         q_s_i,
  input  logic [PIX_W-1:0]         q_w_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [POS_W-1:0]         row_o,
  output logic [POS_W-1:0]         col_o,
  output logic signed [DIFF_W-1:0] diff_north_o,
  output logic signed [DIFF_W-1:0] diff_south_o,
  output logic signed [DIFF_W-1:0] diff_west_o,
  output logic signed [DIFF_W-1:0] diff_east_o,
  output logic [PIX_W-1:0]         centre_o,
  output logic                     last_o
);

  logic                     valid_q;
  logic [PIX_W-1:0]         east_q;
  logic [POS_W-1:0]         row_q, col_q;
  logic signed [DIFF_W-1:0] dn_q, ds_q, dw_q, de_q;
  logic [PIX_W-1:0]         ctr_q;
  logic                     last_q;
  logic [DIFF_W-1:0]        ctr_x, dn_d, ds_d, dw_d, de_d;
  logic                     east_edge;

  assign take_o    = meta_i.dv && (!valid_q || !out_stall_i);
  assign ctr_x     = {1'b0, q_c_i};
  assign east_edge = (meta_i.col == POS_W'(COLS - 1));

  assign dn_d = {1'b0, q_n_i} - ctr_x;
  assign ds_d = {1'b0, q_s_i} - ctr_x;
  assign dw_d = {1'b0, q_w_i} - ctr_x;
  // east neighbor is the centre of the previous beat in the same row
  assign de_d = east_edge ? '0 : {1'b0, east_q} - ctr_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      east_q <= q_c_i;
      row_q  <= meta_i.row;
      col_q  <= meta_i.col;
      dn_q   <= signed'(dn_d);
      ds_q   <= signed'(ds_d);
      dw_q   <= signed'(dw_d);
      de_q   <= signed'(de_d);
      ctr_q  <= q_c_i;
      last_q <= meta_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign row_o        = row_q;
  assign col_o        = col_q;
  assign diff_north_o = dn_q;
  assign diff_south_o = ds_q;
  assign diff_west_o  = dw_q;
  assign diff_east_o  = de_q;
  assign centre_o     = ctr_q;
  assign last_o       = last_q;

  a_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_o)
    else $error("taken beat not presented");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> row_o == '0 && col_o == '0)
    else $error("last flag off origin");

  a_east_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && col_o == POS_W'(COLS - 1) |-> diff_east_o == '0)
    else $error("east edge not clamped");

endmodule

FILE: design/block_stencil_directional_diff_top.sv
// Top level of the clamped block directional difference unit.
//
//  channel  valid        stall         payload
//  -------  -----------  ------------  ------------------------------------------
//  in       in_valid_i   in_stall_o    pixel_i
//  out      out_valid_o  out_stall_i   row_o col_o diff_*_o centre_o last_o
//
// Load: one pixel per cycle, 64 pixels per block, written to four RAM copies.
// Emit: one record per cycle while out_stall_i is low, in reverse raster order;
// the first record follows the last pixel through the RAM read and output register.
// Input is stalled from the last pixel until the final record enters the
// output register.
// Output stalls hold the RAM read data; reads resume when the register frees.
// Reset clears control only; RAM contents are not cleared.
module block_stencil_directional_diff_top import sdd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [PIX_W-1:0]         pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [POS_W-1:0]         row_o,
  output logic [POS_W-1:0]         col_o,
  output logic signed [DIFF_W-1:0] diff_north_o,
  output logic signed [DIFF_W-1:0] diff_south_o,
  output logic signed [DIFF_W-1:0] diff_west_o,
  output logic signed [DIFF_W-1:0] diff_east_o,
  output logic [PIX_W-1:0]         centre_o,
  output logic                     last_o
);

  logic              we, re, take;
  logic [ADDR_W-1:0] waddr, ra_n, ra_c, ra_s, ra_w;
  logic [PIX_W-1:0]  q_n, q_c, q_s, q_w;
  sdd_rd_meta_t      meta;

  sdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .we_o       (we),
    .waddr_o    (waddr),
    .re_o       (re),
    .raddr_n_o  (ra_n),
    .raddr_c_o  (ra_c),
    .raddr_s_o  (ra_s),
    .raddr_w_o  (ra_w),
    .meta_o     (meta),
    .take_i     (take)
  );

  sdd_ram #(.WIDTH(PIX_W), .DEPTH(PIX), .AW(ADDR_W)) u_ram_n (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(pixel_i),
    .re_i(re), .raddr_i(ra_n), .rdata_o(q_n)
  );

  sdd_ram #(.WIDTH(PIX_W), .DEPTH(PIX), .AW(ADDR_W)) u_ram_c (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(pixel_i),
    .re_i(re), .raddr_i(ra_c), .rdata_o(q_c)
  );

  sdd_ram #(.WIDTH(PIX_W), .DEPTH(PIX), .AW(ADDR_W)) u_ram_s (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(pixel_i),
    .re_i(re), .raddr_i(ra_s), .rdata_o(q_s)
  );

  sdd_ram #(.WIDTH(PIX_W), .DEPTH(PIX), .AW(ADDR_W)) u_ram_w (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(pixel_i),
    .re_i(re), .raddr_i(ra_w), .rdata_o(q_w)
  );

  sdd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meta_i       (meta),
    .q_n_i        (q_n),
    .q_c_i        (q_c),
    .q_s_i        (q_s),
    .q_w_i        (q_w),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_o        (row_o),
    .col_o        (col_o),
    .diff_north_o (diff_north_o),
    .diff_south_o (diff_south_o),
    .diff_west_o  (diff_west_o),
    .diff_east_o  (diff_east_o),
    .centre_o     (centre_o),
    .last_o       (last_o)
  );

endmodule
